>>> rtl/rles_pkg.sv
`default_nettype none
package rles_pkg;

  localparam int MaxChannels = 8;
  localparam int EntryW = $clog2(MaxChannels);

  typedef enum logic [3:0] {
    OP_VALID    = 4'd0,
    OP_CRC_FAIL = 4'd1,
    OP_TIMEOUT  = 4'd2,
    OP_SYNC_GOT = 4'd3,
    OP_SYNC_LOST = 4'd4,
    OP_MISS     = 4'd5,
    OP_RECOV_IN = 4'd6,
    OP_RECOV_OK = 4'd7,
    OP_HARD     = 4'd8,
    OP_CORRECT  = 4'd9,
    OP_READ     = 4'd10,
    OP_CLEAR    = 4'd11
  } op_t;

  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_LIST_LO = 2'd1;
  localparam logic [1:0] REG_LIST_HI = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic update;   // apply the captured event
  } rles_cmd_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [7:0]  channel;
    logic [31:0] signed_value;
    logic [31:0] miss_count;
    logic [47:0] timestamp;
    logic [5:0]  read_index;
  } event_t;

endpackage
`default_nettype wire

>>> rtl/rles_ctrl.sv
`default_nettype none
module rles_ctrl
  import rles_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_fire,
  input  wire logic      out_fire,
  output rles_cmd_t      cmd,
  output logic           busy,
  output logic           out_valid
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_HOLD} state_t;
  state_t state;

  assign cmd.update = (state == S_EXEC);
  assign busy = (state != S_IDLE) && !(state == S_HOLD && out_fire);

  // capture -> execute -> present result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_fire) state <= S_EXEC;
        S_EXEC: begin
          state <= S_HOLD;
          out_valid <= 1'b1;
        end
        S_HOLD: if (out_fire) begin
          out_valid <= 1'b0;
          state <= in_fire ? S_EXEC : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/rles_datapath.sv
`default_nettype none
module rles_datapath
  import rles_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_fire,
  input  wire event_t      ev_in,
  input  wire rles_cmd_t   cmd,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic [63:0]      read_data,
  output logic             channel_matched
);

  event_t ev;
  logic [3:0]  table_size;
  logic [31:0] list_lo, list_hi;

  logic [31:0] valid_total, crc_fail_total, timeout_total, sync_gained_total;
  logic [31:0] sync_lost_total, longest_miss_run, recovery_entries;
  logic [31:0] recovery_successes, hard_search_total, corrections_applied;
  logic [63:0] correction_magnitude_sum;
  logic [31:0] correction_magnitude_max;
  logic [31:0] timing_min, timing_max;
  logic [63:0] timing_sum;
  logic [31:0] timing_samples;
  logic [47:0] last_valid_time, recovery_start_time;
  logic [63:0] recovery_duration_sum;
  logic [31:0] recovery_duration_count;
  logic [47:0] recovery_duration_max;
  logic [31:0] pc_valid [MaxChannels];
  logic [31:0] pc_crc [MaxChannels];
  logic [31:0] pc_tmo [MaxChannels];

  // event capture
  always_ff @(posedge clk) begin
    if (in_fire) ev <= ev_in;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= 4'd1;
      list_lo <= '0;
      list_hi <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COUNT:   table_size <= cfg_data[3:0];
        REG_LIST_LO: list_lo <= cfg_data;
        REG_LIST_HI: list_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  // channel table search, first match wins
  logic [63:0] list_all;
  logic [4:0]  n_eff;
  logic             hit;
  logic [EntryW-1:0] hit_idx;
  assign list_all = {list_hi, list_lo};
  assign n_eff = (table_size > 4'(MaxChannels)) ? 5'(MaxChannels)
                                                : {1'b0, table_size};
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int i = MaxChannels - 1; i >= 0; i--) begin
      if (5'(i) < n_eff && list_all[8*i +: 8] == ev.channel) begin
        hit = 1'b1;
        hit_idx = EntryW'(i);
      end
    end
  end

  logic is_chan;
  assign is_chan = (ev.op == OP_VALID) || (ev.op == OP_CRC_FAIL) ||
                   (ev.op == OP_TIMEOUT);

  logic [31:0] sv_mag;
  logic        sv_neg;
  assign sv_neg = ev.signed_value[31];
  assign sv_mag = sv_neg ? (32'd0 - ev.signed_value) : ev.signed_value;

  logic [47:0] dur;
  logic        dur_ok;
  assign dur = ev.timestamp - recovery_start_time;
  assign dur_ok = (recovery_start_time != '0) && (ev.timestamp >= recovery_start_time);

  // read selection; per-channel counters decoded against constant indices
  logic [63:0] rd;
  always_comb begin
    rd = '0;
    case (ev.read_index)
      6'd0:  rd = {32'd0, valid_total};
      6'd1:  rd = {32'd0, crc_fail_total};
      6'd2:  rd = {32'd0, timeout_total};
      6'd3:  rd = {32'd0, sync_gained_total};
      6'd4:  rd = {32'd0, sync_lost_total};
      6'd5:  rd = {32'd0, longest_miss_run};
      6'd6:  rd = {32'd0, recovery_entries};
      6'd7:  rd = {32'd0, recovery_successes};
      6'd8:  rd = {32'd0, hard_search_total};
      6'd9:  rd = {32'd0, corrections_applied};
      6'd10: rd = correction_magnitude_sum;
      6'd11: rd = {32'd0, correction_magnitude_max};
      6'd12: rd = {{32{timing_min[31]}}, timing_min};
      6'd13: rd = {{32{timing_max[31]}}, timing_max};
      6'd14: rd = timing_sum;
      6'd15: rd = {32'd0, timing_samples};
      6'd16: rd = {16'd0, last_valid_time};
      6'd17: rd = {16'd0, recovery_start_time};
      6'd18: rd = recovery_duration_sum;
      6'd19: rd = {32'd0, recovery_duration_count};
      6'd20: rd = {16'd0, recovery_duration_max};
      default: begin
        for (int i = 0; i < MaxChannels; i++) begin
          if (ev.read_index == 6'(21 + 3 * i)) rd = {32'd0, pc_valid[i]};
          if (ev.read_index == 6'(22 + 3 * i)) rd = {32'd0, pc_crc[i]};
          if (ev.read_index == 6'(23 + 3 * i)) rd = {32'd0, pc_tmo[i]};
        end
      end
    endcase
  end

  // statistics update
  always_ff @(posedge clk) begin
    if (rst || (cmd.update && ev.op == OP_CLEAR)) begin
      valid_total <= '0; crc_fail_total <= '0; timeout_total <= '0;
      sync_gained_total <= '0; sync_lost_total <= '0; longest_miss_run <= '0;
      recovery_entries <= '0; recovery_successes <= '0; hard_search_total <= '0;
      corrections_applied <= '0; correction_magnitude_sum <= '0;
      correction_magnitude_max <= '0; timing_min <= '0; timing_max <= '0;
      timing_sum <= '0; timing_samples <= '0; last_valid_time <= '0;
      recovery_start_time <= '0; recovery_duration_sum <= '0;
      recovery_duration_count <= '0; recovery_duration_max <= '0;
      for (int i = 0; i < MaxChannels; i++) begin
        pc_valid[i] <= '0; pc_crc[i] <= '0; pc_tmo[i] <= '0;
      end
    end else if (cmd.update) begin
      case (ev.op)
        OP_VALID: begin
          valid_total <= valid_total + 32'd1;
          if (hit) pc_valid[hit_idx] <= pc_valid[hit_idx] + 32'd1;
          if (timing_samples == '0) begin
            timing_min <= ev.signed_value;
            timing_max <= ev.signed_value;
          end else begin
            if ($signed(ev.signed_value) < $signed(timing_min))
              timing_min <= ev.signed_value;
            if ($signed(ev.signed_value) > $signed(timing_max))
              timing_max <= ev.signed_value;
          end
          timing_sum <= timing_sum + {{32{sv_neg}}, ev.signed_value};
          timing_samples <= timing_samples + 32'd1;
          last_valid_time <= ev.timestamp;
        end
        OP_CRC_FAIL: begin
          crc_fail_total <= crc_fail_total + 32'd1;
          if (hit) pc_crc[hit_idx] <= pc_crc[hit_idx] + 32'd1;
        end
        OP_TIMEOUT: begin
          timeout_total <= timeout_total + 32'd1;
          if (hit) pc_tmo[hit_idx] <= pc_tmo[hit_idx] + 32'd1;
        end
        OP_SYNC_GOT:  sync_gained_total <= sync_gained_total + 32'd1;
        OP_SYNC_LOST: sync_lost_total <= sync_lost_total + 32'd1;
        OP_MISS: if (ev.miss_count > longest_miss_run) longest_miss_run <= ev.miss_count;
        OP_RECOV_IN: begin
          recovery_entries <= recovery_entries + 32'd1;
          recovery_start_time <= ev.timestamp;
        end
        OP_RECOV_OK: begin
          recovery_successes <= recovery_successes + 32'd1;
          if (dur_ok) begin
            recovery_duration_sum <= recovery_duration_sum + {16'd0, dur};
            recovery_duration_count <= recovery_duration_count + 32'd1;
            if (dur > recovery_duration_max) recovery_duration_max <= dur;
          end
          recovery_start_time <= '0;
        end
        OP_HARD: begin
          hard_search_total <= hard_search_total + 32'd1;
          recovery_start_time <= '0;
        end
        OP_CORRECT: if (ev.signed_value != '0) begin
          corrections_applied <= corrections_applied + 32'd1;
          correction_magnitude_sum <= correction_magnitude_sum + {32'd0, sv_mag};
          if (sv_mag > correction_magnitude_max) correction_magnitude_max <= sv_mag;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      read_data <= (ev.op == OP_READ) ? rd : '0;
      channel_matched <= is_chan && hit;
    end
  end

endmodule
`default_nettype wire

>>> rtl/radio_link_event_statistics_unit.sv
// Radio link event statistics unit.
// Input stream (s_axis_*): one event per transfer; tdata packs op, channel,
// signed_value, miss_count, timestamp, read_index. Each event yields exactly
// one result transfer on m_axis_* (read_data in tdata, channel_matched in
// tuser). read_data is nonzero only for read events.
// Timing: the event is captured on accept and applied in the next cycle
// (S_EXEC), where the result and m_axis_tvalid are registered.
// Flow: events are taken one at a time through the capture, execute and hold
// states of the controller; the next event is taken in the same cycle the
// pending result is transferred.
// Configuration: cfg_we/cfg_index/cfg_data write the table size (0),
// channel_list_low (1) and channel_list_high (2); write only when idle.
// Reset (rst, synchronous): all statistics to zero, table size to 1,
// channel lists to zero, no result pending.
// Output stall: the result holds on m_axis_tdata until taken; no new event
// is accepted meanwhile.
`default_nettype none
module radio_link_event_statistics_unit
  import rles_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // op[3:0], channel[11:4], signed_value[43:12], miss_count[75:44],
  // timestamp[123:76], read_index[129:124], zero pad to 136
  input  wire logic [135:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // read_data[63:0]
  output logic [63:0]       m_axis_tdata,
  // channel_matched[0]
  output logic              m_axis_tuser,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  rles_cmd_t cmd;
  logic      busy, in_fire, out_fire;
  event_t    ev_in;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign ev_in = {s_axis_tdata[3:0], s_axis_tdata[11:4], s_axis_tdata[43:12],
                  s_axis_tdata[75:44], s_axis_tdata[123:76], s_axis_tdata[129:124]};

  rles_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_fire, .cmd, .busy, .out_valid(m_axis_tvalid)
  );

  rles_datapath u_dp (
    .clk, .rst, .in_fire, .ev_in, .cmd, .cfg_we, .cfg_index, .cfg_data,
    .read_data(m_axis_tdata), .channel_matched(m_axis_tuser)
  );

endmodule
`default_nettype wire

>>> sim/radio_link_event_statistics_unit_test.sv
`timescale 1ns / 100ps
`default_nettype none
module radio_link_event_statistics_unit_test;
  import rles_pkg::*;

  localparam int LimitCycles = 400000;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic [3:0]  op;
    logic [7:0]  channel;
    logic [31:0] signed_value;
    logic [31:0] miss_count;
    logic [47:0] timestamp;
    logic [5:0]  read_index;
  } link_event_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        matched;
  } stat_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  radio_link_event_statistics_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state
  logic [3:0]  chan_count;
  logic [31:0] chan_list_lo, chan_list_hi;
  logic [31:0] valid_cnt, crc_cnt, tmo_cnt, sync_got_cnt, sync_lost_cnt, miss_max;
  logic [31:0] recov_in_cnt, recov_ok_cnt, hard_cnt, corr_cnt, corr_mag_max;
  logic [63:0] corr_mag_sum;
  logic signed [31:0] err_min, err_max;
  logic [63:0] err_sum;
  logic [31:0] err_samples;
  logic [47:0] last_valid_ts, recov_start_ts, recov_dur_max;
  logic [63:0] recov_dur_sum;
  logic [31:0] recov_dur_cnt;
  logic [31:0] ch_valid [8];
  logic [31:0] ch_crc [8];
  logic [31:0] ch_tmo [8];

  link_event_t  pending_events[$];
  stat_result_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  int outstanding = 0;

  function automatic void clear_stats();
    {valid_cnt, crc_cnt, tmo_cnt, sync_got_cnt, sync_lost_cnt, miss_max} = '0;
    {recov_in_cnt, recov_ok_cnt, hard_cnt, corr_cnt, corr_mag_max} = '0;
    corr_mag_sum = '0;
    err_min = '0;
    err_max = '0;
    err_sum = '0;
    err_samples = '0;
    last_valid_ts = '0;
    recov_start_ts = '0;
    recov_dur_max = '0;
    recov_dur_sum = '0;
    recov_dur_cnt = '0;
    for (int i = 0; i < 8; i++) begin
      ch_valid[i] = '0;
      ch_crc[i] = '0;
      ch_tmo[i] = '0;
    end
  endfunction

  // port layout: op in the lowest bits, read_index highest
  function automatic logic [135:0] pack_event(link_event_t ev);
    return {6'd0, ev.read_index, ev.timestamp, ev.miss_count, ev.signed_value,
            ev.channel, ev.op};
  endfunction

  function automatic link_event_t unpack_event(logic [135:0] d);
    link_event_t ev;
    ev.op = d[3:0];
    ev.channel = d[11:4];
    ev.signed_value = d[43:12];
    ev.miss_count = d[75:44];
    ev.timestamp = d[123:76];
    ev.read_index = d[129:124];
    return ev;
  endfunction

  function automatic int find_entry(logic [7:0] ch);
    int n;
    logic [63:0] table_bits;
    n = (chan_count > MaxChannels) ? MaxChannels : int'(chan_count);
    table_bits = {chan_list_hi, chan_list_lo};
    for (int i = 0; i < n; i++)
      if (table_bits[8*i +: 8] == ch) return i;
    return -1;
  endfunction

  function automatic logic [63:0] read_stat(logic [5:0] idx);
    int e, k;
    case (idx)
      6'd0:  return 64'(valid_cnt);
      6'd1:  return 64'(crc_cnt);
      6'd2:  return 64'(tmo_cnt);
      6'd3:  return 64'(sync_got_cnt);
      6'd4:  return 64'(sync_lost_cnt);
      6'd5:  return 64'(miss_max);
      6'd6:  return 64'(recov_in_cnt);
      6'd7:  return 64'(recov_ok_cnt);
      6'd8:  return 64'(hard_cnt);
      6'd9:  return 64'(corr_cnt);
      6'd10: return corr_mag_sum;
      6'd11: return 64'(corr_mag_max);
      6'd12: return 64'(err_min);
      6'd13: return 64'(err_max);
      6'd14: return err_sum;
      6'd15: return 64'(err_samples);
      6'd16: return 64'(last_valid_ts);
      6'd17: return 64'(recov_start_ts);
      6'd18: return recov_dur_sum;
      6'd19: return 64'(recov_dur_cnt);
      6'd20: return 64'(recov_dur_max);
      default: ;
    endcase
    e = (int'(idx) - 21) / 3;
    k = (int'(idx) - 21) % 3;
    if (e >= MaxChannels) return '0;
    if (k == 0) return 64'(ch_valid[e]);
    if (k == 1) return 64'(ch_crc[e]);
    return 64'(ch_tmo[e]);
  endfunction

  // apply one event to the statistics and return the expected result
  function automatic stat_result_t apply_event(link_event_t ev);
    stat_result_t r;
    int e;
    logic signed [31:0] sv;
    logic [31:0] mag;
    logic [47:0] dur;
    r = '0;
    e = -1;
    sv = ev.signed_value;
    if (ev.op <= OP_TIMEOUT) begin
      e = find_entry(ev.channel);
      r.matched = (e >= 0);
    end
    case (ev.op)
      OP_VALID: begin
        valid_cnt++;
        if (e >= 0) ch_valid[e]++;
        if (err_samples == 0) begin
          err_min = sv;
          err_max = sv;
        end else begin
          if (sv < err_min) err_min = sv;
          if (sv > err_max) err_max = sv;
        end
        err_sum += 64'(sv);
        err_samples++;
        last_valid_ts = ev.timestamp;
      end
      OP_CRC_FAIL: begin
        crc_cnt++;
        if (e >= 0) ch_crc[e]++;
      end
      OP_TIMEOUT: begin
        tmo_cnt++;
        if (e >= 0) ch_tmo[e]++;
      end
      OP_SYNC_GOT: sync_got_cnt++;
      OP_SYNC_LOST: sync_lost_cnt++;
      OP_MISS: if (ev.miss_count > miss_max) miss_max = ev.miss_count;
      OP_RECOV_IN: begin
        recov_in_cnt++;
        recov_start_ts = ev.timestamp;
      end
      OP_RECOV_OK: begin
        recov_ok_cnt++;
        if (recov_start_ts != 0 && ev.timestamp >= recov_start_ts) begin
          dur = ev.timestamp - recov_start_ts;
          recov_dur_sum += 64'(dur);
          recov_dur_cnt++;
          if (dur > recov_dur_max) recov_dur_max = dur;
        end
        recov_start_ts = '0;
      end
      OP_HARD: begin
        hard_cnt++;
        recov_start_ts = '0;
      end
      OP_CORRECT: if (sv != 0) begin
        mag = sv[31] ? (32'd0 - sv) : sv;
        corr_cnt++;
        corr_mag_sum += 64'(mag);
        if (mag > corr_mag_max) corr_mag_max = mag;
      end
      OP_READ: r.read_data = read_stat(ev.read_index);
      OP_CLEAR: clear_stats();
      default: ;
    endcase
    return r;
  endfunction

  // sender: per-item gap, then hold the transfer until accepted
  int send_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_event(unpack_event(s_axis_tdata)));
        send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        if (pending_events.size() > 0 && send_gap == 0) begin
          s_axis_tdata <= pack_event(pending_events.pop_front());
          outstanding++;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end else if (!s_axis_tvalid && pending_events.size() > 0) begin
        if (send_gap > 0) send_gap--;
        else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pack_event(pending_events.pop_front());
          outstanding++;
        end
      end
    end
  end

  // receiver: random stall per result, then compare
  int recv_gap = 0;
  stat_result_t want;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result data=%h matched=%b", $time, m_axis_tdata,
                   m_axis_tuser);
          errors++;
        end else begin
          want = expected_results.pop_front();
          outstanding--;
          if (want.read_data !== m_axis_tdata) begin
            $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                     m_axis_tdata);
            errors++;
          end
          if (want.matched !== m_axis_tuser) begin
            $display("%0t: channel_matched expected %b actual %b", $time, want.matched,
                     m_axis_tuser);
            errors++;
          end
        end
        recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        m_axis_tready <= (recv_gap == 0);
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= (recv_gap == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // timeout watchdog
  always @(posedge clk) begin
    if (cycles > LimitCycles) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic link_event_t make_event(op_t op, logic [7:0] ch, logic [31:0] sv,
                                             logic [31:0] miss, logic [47:0] ts,
                                             logic [5:0] idx);
    link_event_t ev;
    ev.op = op;
    ev.channel = ch;
    ev.signed_value = sv;
    ev.miss_count = miss;
    ev.timestamp = ts;
    ev.read_index = idx;
    return ev;
  endfunction

  function automatic logic [47:0] rand_ts();
    case ($urandom_range(0, 3))
      0: return 48'(0);
      1: return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 3));
      2: return 48'($urandom_range(0, 1000));
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 40)) - 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic link_event_t rand_event(logic [63:0] table_bits);
    link_event_t ev;
    ev = '0;
    ev.channel = 8'($urandom);
    ev.read_index = 6'($urandom);
    ev.op = 4'($urandom_range(0, 13) > 12 ? $urandom_range(12, 15) : $urandom_range(0, 11));
    if (ev.op == OP_CLEAR && $urandom_range(0, 3) != 0) ev.op = OP_READ;
    if ($urandom_range(0, 2) != 0) ev.channel = table_bits[8*$urandom_range(0, 7) +: 8];
    ev.signed_value = rand_word();
    ev.miss_count = rand_word();
    ev.timestamp = rand_ts();
    if (ev.op == OP_READ && $urandom_range(0, 4) != 0) ev.read_index = 6'($urandom_range(0, 44));
    return ev;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COUNT: chan_count = value[3:0];
      REG_LIST_LO: chan_list_lo = value;
      default: chan_list_hi = value;
    endcase
  endtask

  // every popped item counts as outstanding until its result is checked
  task automatic wait_idle();
    while (pending_events.size() > 0 || outstanding > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  logic [3:0] phase_counts[6] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd9};
  link_event_t ev;
  initial begin
    chan_count = 4'd1;
    chan_list_lo = '0;
    chan_list_hi = '0;
    clear_stats();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: table with a duplicate so first match wins
    write_reg(REG_COUNT, 32'd8);
    write_reg(REG_LIST_LO, 32'h05FF_0500);
    write_reg(REG_LIST_HI, 32'h8001_7F42);
    pending_events.push_back(make_event(OP_VALID, 8'h05, 32'h8000_0000, '0, 48'hFFFF_FFFF_FFFF, '0));
    pending_events.push_back(make_event(OP_VALID, 8'h80, 32'h7FFF_FFFF, '0, 48'd5, '0));
    pending_events.push_back(make_event(OP_CRC_FAIL, 8'hFF, '0, '0, '0, '0));
    pending_events.push_back(make_event(OP_TIMEOUT, 8'h33, '0, '0, '0, '0));
    pending_events.push_back(make_event(OP_SYNC_GOT, '0, '0, '0, '0, '0));
    pending_events.push_back(make_event(OP_SYNC_LOST, '0, '0, '0, '0, '0));
    pending_events.push_back(make_event(OP_MISS, '0, '0, 32'hFFFF_FFFF, '0, '0));
    pending_events.push_back(make_event(OP_RECOV_OK, '0, '0, '0, 48'd100, '0));
    pending_events.push_back(make_event(OP_RECOV_IN, '0, '0, '0, 48'd0, '0));
    pending_events.push_back(make_event(OP_RECOV_OK, '0, '0, '0, 48'd50, '0));
    pending_events.push_back(make_event(OP_RECOV_IN, '0, '0, '0, 48'd1000, '0));
    pending_events.push_back(make_event(OP_RECOV_OK, '0, '0, '0, 48'd10, '0));
    pending_events.push_back(make_event(OP_RECOV_IN, '0, '0, '0, 48'd1, '0));
    pending_events.push_back(make_event(OP_RECOV_OK, '0, '0, '0, 48'hFFFF_FFFF_FFFF, '0));
    pending_events.push_back(make_event(OP_RECOV_IN, '0, '0, '0, 48'd7, '0));
    pending_events.push_back(make_event(OP_HARD, '0, '0, '0, '0, '0));
    pending_events.push_back(make_event(OP_CORRECT, '0, 32'd0, '0, '0, '0));
    pending_events.push_back(make_event(OP_CORRECT, '0, 32'h8000_0000, '0, '0, '0));
    pending_events.push_back(make_event(OP_CORRECT, '0, 32'hFFFF_FFFF, '0, '0, '0));
    for (int i = 0; i < 64; i++)
      pending_events.push_back(make_event(OP_READ, '0, '0, '0, '0, 6'(i)));
    pending_events.push_back(make_event(op_t'(4'd15), 8'h05, '1, '1, '1, '1));
    pending_events.push_back(make_event(OP_CLEAR, '0, '0, '0, '0, '0));
    pending_events.push_back(make_event(OP_READ, '0, '0, '0, '0, 6'd12));
    wait_idle();

    // random phases over several table settings
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_COUNT, 32'(phase_counts[p]));
      write_reg(REG_LIST_LO, p == 1 ? 32'hFFFF_FFFF : $urandom);
      write_reg(REG_LIST_HI, p == 1 ? 32'h0 : $urandom);
      for (int i = 0; i < 280; i++) begin
        ev = rand_event({chan_list_hi, chan_list_lo});
        pending_events.push_back(ev);
      end
      for (int i = 0; i < 45; i++)
        pending_events.push_back(make_event(OP_READ, '0, '0, '0, '0, 6'(i)));
      wait_idle();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
